// File: hdl/ccc_pkg.sv
// ---------------------------------------------------------------------------
// Coin credit controller package
// Operation codes, command bytes, reply bytes and field widths shared by
// the coin credit controller.
// ---------------------------------------------------------------------------
package ccc_pkg;

  // Operation codes carried in tuser.
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_READ_DATA  = 3'd1;
  localparam logic [2:0] OP_READ_STAT  = 3'd2;
  localparam logic [2:0] OP_WRITE_DATA = 3'd3;
  localparam logic [2:0] OP_WRITE_CMD  = 3'd4;
  localparam logic [2:0] OP_SOFT_RESET = 3'd5;

  // Command bytes.
  localparam logic [7:0] CMD_READ_CREDITS = 8'h41;
  localparam logic [7:0] CMD_CREDITS_BTN  = 8'hc1;
  localparam logic [7:0] CMD_CONTINUE     = 8'h15;

  // Reply bytes.
  localparam logic [7:0] REPLY_TILT_RESTART = 8'hee;
  localparam logic [7:0] REPLY_UNKNOWN      = 8'hff;
  localparam logic [7:0] STAT_TILT          = 8'he1;
  localparam logic [7:0] STAT_COIN_A        = 8'h11;
  localparam logic [7:0] STAT_COIN_B        = 8'h21;
  localparam logic [7:0] STAT_SERVICE       = 8'h31;
  localparam logic [7:0] STAT_IDLE          = 8'h01;

  // Credit ceiling that also locks the slots.
  localparam logic [7:0] CREDIT_MAX = 8'd9;

  // Startup handshake length and default coinage entry.
  localparam logic [1:0] STARTUP_LEN   = 2'd3;
  localparam logic [7:0] COINAGE_RESET = 8'd1;

  // Coin pattern bit positions.
  localparam int COIN_A    = 0;
  localparam int COIN_B    = 1;
  localparam int COIN_SERV = 2;
  localparam int COIN_TILT = 3;

  typedef logic [7:0] byte_t;

  // Handshake byte for a data read, by the count still left before the read.
  function automatic byte_t hello_byte(input logic [1:0] left);
    byte_t b;
    case (left)
      2'd3:    b = 8'h55;
      2'd2:    b = 8'haa;
      2'd1:    b = 8'h5a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/coin_credit_controller_unit.sv
// ---------------------------------------------------------------------------
// Coin credit controller
// Coin slot counting, credit bookkeeping and the byte-port command protocol,
// one transaction in and one transaction out per operation.
// ---------------------------------------------------------------------------
// Channel  Dir  tdata                                           tuser
// s_axis   in   [3:0] coin_bits, [11:4] write_byte,             [2:0] opcode
//               [19:12] button_bits, [23:20] zero
// m_axis   out  [7:0] read_byte, [8] slots_locked,              -
//               [9] count_pulse_a, [10] count_pulse_b, [15:11] zero
//
// An accepted transaction is held in the input register; the state update and
// result are computed from it and land in the output register, and one
// transaction is taken per cycle while the output is not stalled. A stalled
// output holds both stages; the input side keeps accepting while the input
// register is empty or moving forward. rst (synchronous) clears the valid
// flags and all controller state to their power-up values.
// ---------------------------------------------------------------------------
module coin_credit_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // coin_bits, write_byte, button_bits
  input  logic [2:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // read_byte, slots_locked, pulse a, pulse b
);

  // Input register.
  logic       in_valid;
  logic [2:0] in_op;
  logic [3:0] in_coin;
  logic [7:0] in_wbyte;
  logic [7:0] in_btn;
  logic       advance;

  // Output register.
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_lock;
  logic       out_pa;
  logic       out_pb;

  // Controller state.
  logic [1:0] startup_left;
  logic [1:0] coinage_index;
  logic [7:0] coinage_table [4];
  logic [7:0] slot_a_coins;
  logic [7:0] slot_b_coins;
  logic [7:0] credit_count;
  logic [3:0] reported_coin;
  logic [7:0] last_command;
  logic       credits_already_read;
  logic [3:0] previous_coin;
  logic       lock_level;

  logic [1:0] startup_left_next;
  logic [1:0] coinage_index_next;
  logic [7:0] coinage_table_next [4];
  logic [7:0] slot_a_coins_next;
  logic [7:0] slot_b_coins_next;
  logic [7:0] credit_count_next;
  logic [3:0] reported_coin_next;
  logic [7:0] last_command_next;
  logic       credits_already_read_next;
  logic [3:0] previous_coin_next;
  logic       lock_level_next;
  logic [7:0] byte_next;
  logic       pa_next;
  logic       pb_next;

  // Tick datapath intermediates.
  logic [7:0] tally_a_inc;
  logic [7:0] tally_b_inc;
  logic       pay_a;
  logic       pay_b;
  logic [8:0] sum_a;
  logic [8:0] sum_b;
  logic [7:0] cred_after_a;
  logic [7:0] cred_after_b;
  logic       lock_after_a;
  logic       lock_after_b;

  // Handshake: the input stage moves whenever the output register is free.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_pb, out_pa, out_lock, out_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_op    <= s_axis_tuser;
      in_coin  <= s_axis_tdata[3:0];
      in_wbyte <= s_axis_tdata[11:4];
      in_btn   <= s_axis_tdata[19:12];
    end
  end

  // Slot A then slot B payout, each seeing the credits left by the one before.
  always_comb begin
    tally_a_inc  = slot_a_coins + 8'd1;
    pay_a        = in_coin[ccc_pkg::COIN_A] && (tally_a_inc >= coinage_table[0]);
    sum_a        = {1'b0, credit_count} + {1'b0, coinage_table[1]};
    cred_after_a = credit_count;
    lock_after_a = lock_level;
    if (pay_a) begin
      if (sum_a >= {1'b0, ccc_pkg::CREDIT_MAX}) begin
        cred_after_a = ccc_pkg::CREDIT_MAX;
        lock_after_a = 1'b1;
      end else begin
        cred_after_a = sum_a[7:0];
        lock_after_a = 1'b0;
      end
    end
    tally_b_inc  = slot_b_coins + 8'd1;
    pay_b        = in_coin[ccc_pkg::COIN_B] && (tally_b_inc >= coinage_table[2]);
    sum_b        = {1'b0, cred_after_a} + {1'b0, coinage_table[3]};
    cred_after_b = cred_after_a;
    lock_after_b = lock_after_a;
    if (pay_b) begin
      if (sum_b >= {1'b0, ccc_pkg::CREDIT_MAX}) begin
        cred_after_b = ccc_pkg::CREDIT_MAX;
        lock_after_b = 1'b1;
      end else begin
        cred_after_b = sum_b[7:0];
        lock_after_b = 1'b0;
      end
    end
  end

  // Next state and result for the operation in the input register.
  always_comb begin
    startup_left_next         = startup_left;
    coinage_index_next        = coinage_index;
    coinage_table_next        = coinage_table;
    slot_a_coins_next         = slot_a_coins;
    slot_b_coins_next         = slot_b_coins;
    credit_count_next         = credit_count;
    reported_coin_next        = reported_coin;
    last_command_next         = last_command;
    credits_already_read_next = credits_already_read;
    previous_coin_next        = previous_coin;
    lock_level_next           = lock_level;
    byte_next                 = 8'd0;
    pa_next                   = 1'b0;
    pb_next                   = 1'b0;

    case (in_op)
      ccc_pkg::OP_TICK: begin
        if (in_coin[ccc_pkg::COIN_TILT]) begin
          reported_coin_next = in_coin;
        end else if (in_coin != 4'd0 && in_coin != previous_coin) begin
          if (in_coin[ccc_pkg::COIN_A]) begin
            pa_next           = 1'b1;
            slot_a_coins_next = pay_a ? tally_a_inc - coinage_table[0] : tally_a_inc;
          end
          if (in_coin[ccc_pkg::COIN_B]) begin
            pb_next           = 1'b1;
            slot_b_coins_next = pay_b ? tally_b_inc - coinage_table[2] : tally_b_inc;
          end
          credit_count_next = cred_after_b +
                              {7'd0, in_coin[ccc_pkg::COIN_SERV]};
          lock_level_next   = lock_after_b;
          reported_coin_next = in_coin;
        end else begin
          if (credit_count < ccc_pkg::CREDIT_MAX) begin
            lock_level_next = 1'b0;
          end
          reported_coin_next = 4'd0;
        end
        previous_coin_next = in_coin;
      end

      ccc_pkg::OP_READ_DATA: begin
        if (startup_left != 2'd0) begin
          startup_left_next = startup_left - 2'd1;
          byte_next         = ccc_pkg::hello_byte(startup_left);
        end else if (last_command == ccc_pkg::CMD_READ_CREDITS) begin
          byte_next = credit_count;
        end else if (last_command == ccc_pkg::CMD_CREDITS_BTN) begin
          if (!credits_already_read) begin
            credits_already_read_next = 1'b1;
            if (reported_coin[ccc_pkg::COIN_TILT]) begin
              startup_left_next = ccc_pkg::STARTUP_LEN;
              byte_next         = ccc_pkg::REPLY_TILT_RESTART;
            end else begin
              byte_next = credit_count;
            end
          end else begin
            byte_next = in_btn;
          end
        end else begin
          byte_next = ccc_pkg::REPLY_UNKNOWN;
        end
      end

      ccc_pkg::OP_READ_STAT: begin
        if (reported_coin[ccc_pkg::COIN_TILT]) begin
          byte_next = ccc_pkg::STAT_TILT;
        end else if (reported_coin[ccc_pkg::COIN_A]) begin
          byte_next = ccc_pkg::STAT_COIN_A;
        end else if (reported_coin[ccc_pkg::COIN_B]) begin
          byte_next = ccc_pkg::STAT_COIN_B;
        end else if (reported_coin[ccc_pkg::COIN_SERV]) begin
          byte_next = ccc_pkg::STAT_SERVICE;
        end else begin
          byte_next = ccc_pkg::STAT_IDLE;
        end
      end

      ccc_pkg::OP_WRITE_DATA: begin
        if (last_command == ccc_pkg::CMD_READ_CREDITS) begin
          credit_count_next = credit_count + in_wbyte;
        end
      end

      ccc_pkg::OP_WRITE_CMD: begin
        if (startup_left != 2'd0) begin
          coinage_table_next[coinage_index] = in_wbyte;
          coinage_index_next                = coinage_index + 2'd1;
        end
        if (in_wbyte == ccc_pkg::CMD_CREDITS_BTN) begin
          credits_already_read_next = 1'b0;
        end
        if (in_wbyte == ccc_pkg::CMD_CONTINUE && credit_count != 8'd0) begin
          credit_count_next = credit_count - 8'd1;
        end
        last_command_next = in_wbyte;
      end

      ccc_pkg::OP_SOFT_RESET: begin
        startup_left_next  = ccc_pkg::STARTUP_LEN;
        coinage_index_next = 2'd0;
        for (int i = 0; i < 4; i++) begin
          coinage_table_next[i] = ccc_pkg::COINAGE_RESET;
        end
        slot_a_coins_next  = 8'd0;
        slot_b_coins_next  = 8'd0;
        credit_count_next  = 8'd0;
        reported_coin_next = 4'd0;
        last_command_next  = 8'd0;
      end

      default: begin
      end
    endcase
  end

  // State and output register update when a transaction moves forward.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid            <= 1'b0;
      startup_left         <= ccc_pkg::STARTUP_LEN;
      coinage_index        <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        coinage_table[i] <= ccc_pkg::COINAGE_RESET;
      end
      slot_a_coins         <= 8'd0;
      slot_b_coins         <= 8'd0;
      credit_count         <= 8'd0;
      reported_coin        <= 4'd0;
      last_command         <= 8'd0;
      credits_already_read <= 1'b0;
      previous_coin        <= 4'd0;
      lock_level           <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        startup_left         <= startup_left_next;
        coinage_index        <= coinage_index_next;
        coinage_table        <= coinage_table_next;
        slot_a_coins         <= slot_a_coins_next;
        slot_b_coins         <= slot_b_coins_next;
        credit_count         <= credit_count_next;
        reported_coin        <= reported_coin_next;
        last_command         <= last_command_next;
        credits_already_read <= credits_already_read_next;
        previous_coin        <= previous_coin_next;
        lock_level           <= lock_level_next;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_byte <= byte_next;
      out_lock <= lock_level_next;
      out_pa   <= pa_next;
      out_pb   <= pb_next;
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Coin credit controller testbench
// Sends directed and random operation transactions through the input stream
// and checks every output transaction against a cycle-free behavioral
// predictor of the controller. Both stream sides idle at random outside the
// gap-free part, and the output side is also held off for a long stretch once.
// ---------------------------------------------------------------------------
module tb;

  // Opcodes that the controller ignores.
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  // Bytes returned by data reads during the startup handshake.
  localparam logic [7:0] HELLO_FIRST  = 8'h55;
  localparam logic [7:0] HELLO_SECOND = 8'haa;
  localparam logic [7:0] HELLO_THIRD  = 8'h5a;

  // Idle patterns, in order: sender light and receiver heavy, then swapped,
  // then none.
  localparam int MODE_RX_SLOW = 0;
  localparam int MODE_TX_SLOW = 1;
  localparam int MODE_NO_IDLE = 2;

  localparam int RANDOM_OPS  = 500;
  localparam int STALL_LEN   = 150;
  localparam int DRAIN_WAIT  = 10;

  typedef struct {
    logic [2:0] op;
    logic [3:0] coin;
    logic [7:0] wbyte;
    logic [7:0] buttons;
    int         mode;
  } op_item_t;

  typedef struct {
    logic [7:0] rbyte;
    logic       locked;
    logic       pulse_a;
    logic       pulse_b;
  } reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // coin_bits, write_byte, button_bits
  logic [2:0]  s_axis_tuser = '0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // read_byte, slots_locked, pulse a, pulse b

  op_item_t pending_ops[$];
  reply_t   expected_replies[$];
  int       mismatches = 0;
  int       accepted_ops = 0;
  int       stall_at = 0;
  int       stall_left = 0;
  bit       stall_done = 1'b0;
  int       cur_mode = MODE_RX_SLOW;

  // Predicted controller state.
  logic [1:0] hello_left;
  logic [1:0] coinage_idx;
  logic [7:0] coinage [4];
  logic [7:0] tally_a;
  logic [7:0] tally_b;
  logic [7:0] credits;
  logic [3:0] shown_coin;
  logic [7:0] last_cmd;
  logic       credits_read;
  logic [3:0] prev_coin;
  logic       lockout;

  coin_credit_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // State restored by a soft reset; the rest survives it.
  function automatic void restore_defaults();
    hello_left  = ccc_pkg::STARTUP_LEN;
    coinage_idx = '0;
    foreach (coinage[i]) coinage[i] = ccc_pkg::COINAGE_RESET;
    tally_a     = '0;
    tally_b     = '0;
    credits     = '0;
    shown_coin  = '0;
    last_cmd    = '0;
  endfunction

  // Count one coin into a slot tally and pay out credits once the price is
  // reached. Returns the new tally.
  function automatic logic [7:0] pay_slot(input logic [7:0] tally,
                                          input logic [7:0] price,
                                          input logic [7:0] amount);
    logic [7:0] t;
    logic [8:0] sum;
    t = tally + 8'd1;
    if (t >= price) begin
      t   = t - price;
      sum = {1'b0, credits} + {1'b0, amount};
      if (sum >= {1'b0, ccc_pkg::CREDIT_MAX}) begin
        credits = ccc_pkg::CREDIT_MAX;
        lockout = 1'b1;
      end else begin
        credits = sum[7:0];
        lockout = 1'b0;
      end
    end
    return t;
  endfunction

  // Apply one operation to the predicted state and return its reply.
  function automatic reply_t predict_reply(input op_item_t it);
    reply_t r;
    r = '{default: '0};
    case (it.op)
      ccc_pkg::OP_TICK: begin
        if (it.coin[ccc_pkg::COIN_TILT]) begin
          shown_coin = it.coin;
        end else if (it.coin != 4'd0 && it.coin != prev_coin) begin
          if (it.coin[ccc_pkg::COIN_A]) begin
            r.pulse_a = 1'b1;
            tally_a   = pay_slot(tally_a, coinage[0], coinage[1]);
          end
          if (it.coin[ccc_pkg::COIN_B]) begin
            r.pulse_b = 1'b1;
            tally_b   = pay_slot(tally_b, coinage[2], coinage[3]);
          end
          if (it.coin[ccc_pkg::COIN_SERV]) credits = credits + 8'd1;
          shown_coin = it.coin;
        end else begin
          if (credits < ccc_pkg::CREDIT_MAX) lockout = 1'b0;
          shown_coin = '0;
        end
        prev_coin = it.coin;
      end
      ccc_pkg::OP_READ_DATA: begin
        if (hello_left != 2'd0) begin
          case (hello_left)
            2'd3:    r.rbyte = HELLO_FIRST;
            2'd2:    r.rbyte = HELLO_SECOND;
            default: r.rbyte = HELLO_THIRD;
          endcase
          hello_left = hello_left - 2'd1;
        end else if (last_cmd == ccc_pkg::CMD_READ_CREDITS) begin
          r.rbyte = credits;
        end else if (last_cmd == ccc_pkg::CMD_CREDITS_BTN) begin
          if (!credits_read) begin
            credits_read = 1'b1;
            if (shown_coin[ccc_pkg::COIN_TILT]) begin
              hello_left = ccc_pkg::STARTUP_LEN;
              r.rbyte    = ccc_pkg::REPLY_TILT_RESTART;
            end else begin
              r.rbyte = credits;
            end
          end else begin
            r.rbyte = it.buttons;
          end
        end else begin
          r.rbyte = ccc_pkg::REPLY_UNKNOWN;
        end
      end
      ccc_pkg::OP_READ_STAT: begin
        if (shown_coin[ccc_pkg::COIN_TILT])      r.rbyte = ccc_pkg::STAT_TILT;
        else if (shown_coin[ccc_pkg::COIN_A])    r.rbyte = ccc_pkg::STAT_COIN_A;
        else if (shown_coin[ccc_pkg::COIN_B])    r.rbyte = ccc_pkg::STAT_COIN_B;
        else if (shown_coin[ccc_pkg::COIN_SERV]) r.rbyte = ccc_pkg::STAT_SERVICE;
        else                                     r.rbyte = ccc_pkg::STAT_IDLE;
      end
      ccc_pkg::OP_WRITE_DATA: begin
        if (last_cmd == ccc_pkg::CMD_READ_CREDITS) credits = credits + it.wbyte;
      end
      ccc_pkg::OP_WRITE_CMD: begin
        // During the handshake the byte also loads the next coinage entry.
        if (hello_left != 2'd0) begin
          coinage[coinage_idx] = it.wbyte;
          coinage_idx          = coinage_idx + 2'd1;
        end
        if (it.wbyte == ccc_pkg::CMD_CREDITS_BTN) credits_read = 1'b0;
        if (it.wbyte == ccc_pkg::CMD_CONTINUE && credits != 8'd0) begin
          credits = credits - 8'd1;
        end
        last_cmd = it.wbyte;
      end
      ccc_pkg::OP_SOFT_RESET: restore_defaults();
      default: ;
    endcase
    r.locked = lockout;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic queue_op(input logic [2:0] op, input logic [3:0] coin,
                          input logic [7:0] wbyte, input logic [7:0] buttons);
    op_item_t it;
    it.op      = op;
    it.coin    = coin;
    it.wbyte   = wbyte;
    it.buttons = buttons;
    it.mode    = MODE_RX_SLOW;
    pending_ops.push_back(it);
  endtask

  // A random command byte, mostly one that the controller acts on.
  function automatic logic [7:0] pick_command();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = ccc_pkg::CMD_READ_CREDITS;
      1:       c = ccc_pkg::CMD_CREDITS_BTN;
      2:       c = ccc_pkg::CMD_CONTINUE;
      default: c = 8'($urandom);
    endcase
    return c;
  endfunction

  // Sender: presents the head of the pending queue and predicts each
  // operation as its transaction is accepted.
  always @(posedge clk) begin : drive_proc
    op_item_t it;
    logic     took;
    logic     valid_n;
    int       idle_pct;
    took    = s_axis_tvalid && s_axis_tready;
    valid_n = s_axis_tvalid;
    if (!rst) begin
      if (took) begin
        it = pending_ops.pop_front();
        expected_replies.push_back(predict_reply(it));
        accepted_ops <= accepted_ops + 1;
      end
      if (!s_axis_tvalid || took) begin
        valid_n = 1'b0;
        if (pending_ops.size() != 0) begin
          it       = pending_ops[0];
          idle_pct = (it.mode == MODE_RX_SLOW) ? 29 : (it.mode == MODE_TX_SLOW) ? 61 : 0;
          if ($urandom_range(0, 99) >= idle_pct) begin
            valid_n = 1'b1;
            s_axis_tdata <= {4'd0, it.buttons, it.wbyte, it.coin};
            s_axis_tuser <= it.op;
            cur_mode     <= it.mode;
          end
        end
      end
    end
    s_axis_tvalid <= valid_n;
  end

  // Long receiver hold-off, started once while the sender runs without gaps.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (!stall_done && stall_at != 0 && accepted_ops >= stall_at) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver: checks every accepted result transaction against the oldest
  // expected reply.
  always @(posedge clk) begin : watch_proc
    reply_t want;
    int     idle_pct;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected result", int'(m_axis_tdata), 0);
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata[7:0] !== want.rbyte)
          report_mismatch("read_byte", int'(m_axis_tdata[7:0]), int'(want.rbyte));
        if (m_axis_tdata[8] !== want.locked)
          report_mismatch("slots_locked", int'(m_axis_tdata[8]), int'(want.locked));
        if (m_axis_tdata[9] !== want.pulse_a)
          report_mismatch("count_pulse_a", int'(m_axis_tdata[9]), int'(want.pulse_a));
        if (m_axis_tdata[10] !== want.pulse_b)
          report_mismatch("count_pulse_b", int'(m_axis_tdata[10]), int'(want.pulse_b));
        if (m_axis_tdata[15:11] !== 5'd0)
          report_mismatch("tdata padding", int'(m_axis_tdata[15:11]), 0);
      end
    end
    idle_pct = (cur_mode == MODE_RX_SLOW) ? 61 : (cur_mode == MODE_TX_SLOW) ? 29 : 0;
    m_axis_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= idle_pct);
  end

  // Stimulus and end of run.
  initial begin : main_proc
    int         counted;
    int         total;
    int         body_len;
    int         pick;
    logic [3:0] last_tick;
    logic [3:0] coin;

    restore_defaults();
    credits_read = 1'b0;
    prev_coin    = '0;
    lockout      = 1'b0;

    // Directed: handshake with coinage load, a zero coin price, saturation,
    // wrapping credits, continue, tilt restart and the ignored opcodes.
    queue_op(ccc_pkg::OP_READ_STAT,  4'h0, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_WRITE_CMD,  4'h0, 8'h01, 8'h00);
    queue_op(ccc_pkg::OP_WRITE_CMD,  4'h0, 8'h02, 8'h00);
    queue_op(ccc_pkg::OP_WRITE_CMD,  4'h0, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_WRITE_CMD,  4'h0, 8'hff, 8'hff);
    queue_op(ccc_pkg::OP_READ_DATA,  4'h0, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_READ_DATA,  4'h0, 8'h00, 8'hff);
    queue_op(ccc_pkg::OP_READ_DATA,  4'h0, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_READ_DATA,  4'h0, 8'h00, 8'hff);
    queue_op(ccc_pkg::OP_WRITE_CMD,  4'h0, ccc_pkg::CMD_READ_CREDITS, 8'h00);
    queue_op(ccc_pkg::OP_TICK,       4'h1, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_TICK,       4'h1, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_TICK,       4'h3, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_READ_STAT,  4'h0, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_TICK,       4'h4, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_WRITE_DATA, 4'h0, 8'hff, 8'h00);
    queue_op(ccc_pkg::OP_READ_DATA,  4'h0, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_WRITE_CMD,  4'h0, ccc_pkg::CMD_CONTINUE, 8'h00);
    queue_op(ccc_pkg::OP_TICK,       4'hf, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_READ_STAT,  4'h0, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_WRITE_CMD,  4'h0, ccc_pkg::CMD_CREDITS_BTN, 8'h00);
    queue_op(ccc_pkg::OP_READ_DATA,  4'h0, 8'h00, 8'h00);
    queue_op(ccc_pkg::OP_SOFT_RESET, 4'h0, 8'h00, 8'h00);
    queue_op(OP_UNUSED_6,            4'hf, 8'hff, 8'hff);
    queue_op(OP_UNUSED_7,            4'h0, 8'h00, 8'h00);

    // Random: mostly sessions that pass the handshake and then play,
    // with bursts of unrestricted noise in between.
    counted   = 0;
    last_tick = '0;
    while (counted < RANDOM_OPS) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_op(ccc_pkg::OP_SOFT_RESET, 4'($urandom), 8'($urandom), 8'($urandom));
        for (int i = 0; i < 4; i++)
          queue_op(ccc_pkg::OP_WRITE_CMD, 4'($urandom),
                   ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
                   8'($urandom));
        for (int i = 0; i < 3; i++)
          queue_op(ccc_pkg::OP_READ_DATA, 4'($urandom), 8'($urandom), 8'($urandom));
        counted += 8;
        body_len = $urandom_range(10, 40);
        for (int i = 0; i < body_len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            if ($urandom_range(0, 9) < 3) begin
              coin = last_tick;
            end else begin
              coin    = 4'($urandom_range(0, 7));
              coin[3] = ($urandom_range(0, 15) == 0);
            end
            last_tick = coin;
            queue_op(ccc_pkg::OP_TICK, coin, 8'($urandom), 8'($urandom));
          end else if (pick < 55) begin
            queue_op(ccc_pkg::OP_READ_STAT, 4'($urandom), 8'($urandom), 8'($urandom));
          end else if (pick < 70) begin
            queue_op(ccc_pkg::OP_READ_DATA, 4'($urandom), 8'($urandom), 8'($urandom));
          end else if (pick < 78) begin
            queue_op(ccc_pkg::OP_WRITE_DATA, 4'($urandom), 8'($urandom), 8'($urandom));
          end else if (pick < 96) begin
            queue_op(ccc_pkg::OP_WRITE_CMD, 4'($urandom), pick_command(), 8'($urandom));
          end else begin
            queue_op(3'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
          end
          counted++;
        end
      end else begin
        body_len = $urandom_range(1, 5);
        for (int i = 0; i < body_len; i++) begin
          queue_op(3'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
          if (pending_ops[$].op <= ccc_pkg::OP_SOFT_RESET) counted++;
        end
      end
    end

    // Split the run into the three idle patterns and place the hold-off
    // early in the gap-free part.
    total = pending_ops.size();
    foreach (pending_ops[i]) pending_ops[i].mode = (i * 3) / total;
    stall_at = (total * 2) / 3 + 20;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
